>>> src/vdl_pkg.sv
// ----------------------------------------------------------------------------
// vdl_pkg
// Shared types and constants of the vertex diffuse lighting unit.
// ----------------------------------------------------------------------------
package vdl_pkg;

  // Default clamp width of the light vector components.
  localparam int COORD_WIDTH_DEF = 32;

  // Internal widths that follow from the fixed field widths.
  localparam int MAGD_W = 40;  // |N.D| in Q16.16, zero extended
  localparam int ROOT_W = 32;  // floor(sqrt) of a 64 bit sum
  localparam int DEN_W  = 50;  // attenuation denominator
  localparam int QUO_W  = 33;  // quotient of 2^32 by the denominator
  localparam int FACT_W = 46;  // saturated diffuse factor

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POSITIONAL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COLORS     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ATT_CONST  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ATT_LIN    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ATT_QUAD   = 3'd7;

  // Input beat.
  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [31:0]        mat_ambient;
    logic [31:0]        mat_diffuse;
    logic [31:0]        mat_emission;
  } in_t;

  // Result beat.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } out_t;

  // Light configuration as seen by the datapath.
  typedef struct packed {
    logic signed [31:0] light_x;
    logic signed [31:0] light_y;
    logic signed [31:0] light_z;
    logic               positional;
    logic [63:0]        colors;
    logic [31:0]        att_const;
    logic [31:0]        att_lin;
    logic [31:0]        att_quad;
  } cfg_t;

  // Shading data that rides alongside the distance and divide chains.
  typedef struct packed {
    logic              neg;
    logic [MAGD_W-1:0] magd;
    logic [31:0]       mat_ambient;
    logic [31:0]       mat_diffuse;
    logic [31:0]       mat_emission;
  } shd_t;

endpackage

>>> src/vdl_front.sv
// ----------------------------------------------------------------------------
// vdl_front
// Light vector, squared distance and normal dot product, three stages.
// ----------------------------------------------------------------------------
module vdl_front #(
  parameter int COORD_WIDTH = vdl_pkg::COORD_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  vdl_pkg::cfg_t cfg,
  input  logic          in_vld,
  input  vdl_pkg::in_t  in_data,
  output logic          out_vld,
  output logic [63:0]   out_sq,
  output vdl_pkg::shd_t out_shd
);

  // Components never need more than 33 bits, whatever the clamp width.
  localparam int DW  = (COORD_WIDTH < 33) ? COORD_WIDTH : 33;
  localparam int SQW = 2 * DW - 1;
  localparam int PW  = 16 + DW;
  localparam logic signed [32:0] DMAX = (33'sd1 <<< (DW - 1)) - 33'sd1;
  localparam logic signed [32:0] DMIN = -(33'sd1 <<< (DW - 1));

  function automatic logic signed [DW-1:0] clamp_d(input logic signed [32:0] v);
    logic signed [DW-1:0] r;
    if (v > DMAX) begin
      r = DMAX[DW-1:0];
    end else if (v < DMIN) begin
      r = DMIN[DW-1:0];
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

  // Stage 1 registers.
  logic                 v1_r;
  logic signed [DW-1:0] d1_r [3];
  logic signed [15:0]   n1_r [3];
  logic [31:0]          ma1_r, md1_r, me1_r;
  // Stage 2 registers.
  logic                 v2_r;
  logic [SQW-1:0]       sq2_r [3];
  logic signed [PW-1:0] p2_r [3];
  logic [31:0]          ma2_r, md2_r, me2_r;
  // Stage 3 registers.
  logic                 v3_r;
  logic [63:0]          sq3_r;
  vdl_pkg::shd_t        shd3_r;

  logic signed [31:0]   lp [3];
  logic signed [31:0]   pp [3];
  logic signed [DW-1:0] d1_nxt [3];
  logic [SQW-1:0]       sq2_nxt [3];
  logic signed [PW-1:0] p2_nxt [3];
  logic [DW-1:0]        mag2 [3];
  logic [SQW-1:0]       low2 [3];
  logic [67:0]          sum3;
  logic signed [PW+1:0] dot3;
  logic [PW+1:0]        dmag3;
  vdl_pkg::shd_t        shd3_nxt;

  // Light vector: from the point to the light, or the light direction itself.
  always_comb begin
    lp[0] = cfg.light_x;
    lp[1] = cfg.light_y;
    lp[2] = cfg.light_z;
    pp[0] = in_data.point_x;
    pp[1] = in_data.point_y;
    pp[2] = in_data.point_z;
    for (int k = 0; k < 3; k++) begin
      if (cfg.positional) begin
        d1_nxt[k] = clamp_d(33'(lp[k]) - 33'(pp[k]));
      end else begin
        d1_nxt[k] = clamp_d(33'(lp[k]));
      end
    end
  end

  // Squares of the component magnitudes and the three normal products.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag2[k] = d1_r[k][DW-1] ? DW'(-d1_r[k]) : DW'(d1_r[k]);
      low2[k] = SQW'(mag2[k][DW-2:0]);
      // The only magnitude with the top bit set is the most negative value.
      sq2_nxt[k] = mag2[k][DW-1] ? (SQW'(1) << (2 * DW - 2)) : low2[k] * low2[k];
      p2_nxt[k]  = PW'(n1_r[k]) * PW'(d1_r[k]);
    end
  end

  // Saturated sum of squares and the dot product magnitude in Q16.16.
  always_comb begin
    sum3  = 68'(sq2_r[0]) + 68'(sq2_r[1]) + 68'(sq2_r[2]);
    dot3  = (PW + 2)'(p2_r[0]) + (PW + 2)'(p2_r[1]) + (PW + 2)'(p2_r[2]);
    dmag3 = dot3[PW+1] ? (PW + 2)'(-dot3) : (PW + 2)'(dot3);
    shd3_nxt.neg          = dot3[PW+1];
    shd3_nxt.magd         = vdl_pkg::MAGD_W'(dmag3 >> 14);
    shd3_nxt.mat_ambient  = ma2_r;
    shd3_nxt.mat_diffuse  = md2_r;
    shd3_nxt.mat_emission = me2_r;
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      d1_r   <= d1_nxt;
      n1_r[0] <= in_data.normal_x;
      n1_r[1] <= in_data.normal_y;
      n1_r[2] <= in_data.normal_z;
      ma1_r  <= in_data.mat_ambient;
      md1_r  <= in_data.mat_diffuse;
      me1_r  <= in_data.mat_emission;
      sq2_r  <= sq2_nxt;
      p2_r   <= p2_nxt;
      ma2_r  <= ma1_r;
      md2_r  <= md1_r;
      me2_r  <= me1_r;
      sq3_r  <= (|sum3[67:64]) ? 64'hFFFF_FFFF_FFFF_FFFF : sum3[63:0];
      shd3_r <= shd3_nxt;
    end
  end

  assign out_vld = v3_r;
  assign out_sq  = sq3_r;
  assign out_shd = shd3_r;

endmodule

>>> src/vdl_sqrt.sv
// ----------------------------------------------------------------------------
// vdl_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module vdl_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [63:0]                in_x,
  input  vdl_pkg::shd_t              in_shd,
  output logic                       out_vld,
  output logic [vdl_pkg::ROOT_W-1:0] out_root,
  output vdl_pkg::shd_t              out_shd
);

  localparam int RW = vdl_pkg::ROOT_W;

  logic          vld_r  [RW];
  logic [63:0]   x_r    [RW];
  logic [RW-1:0] root_r [RW];
  logic [RW+1:0] rem_r  [RW];
  vdl_pkg::shd_t shd_r  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic          vld_in;
    logic [63:0]   x_in;
    logic [RW-1:0] root_in;
    logic [RW+1:0] rem_in;
    vdl_pkg::shd_t shd_in;
    logic [RW+3:0] acc;
    logic [RW+3:0] trial;
    logic          ge;
    logic [RW-1:0] root_nxt;
    logic [RW+1:0] rem_nxt;

    if (k == 0) begin : g_head
      assign vld_in  = in_vld;
      assign x_in    = in_x;
      assign root_in = '0;
      assign rem_in  = '0;
      assign shd_in  = in_shd;
    end else begin : g_body
      assign vld_in  = vld_r[k-1];
      assign x_in    = x_r[k-1];
      assign root_in = root_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign shd_in  = shd_r[k-1];
    end

    // Bring down the next bit pair and try root*4+1 against the remainder.
    always_comb begin
      acc      = {rem_in, x_in[2 * (RW - 1 - k) + 1 -: 2]};
      trial    = (RW + 4)'({root_in, 2'b01});
      ge       = (acc >= trial);
      root_nxt = {root_in[RW-2:0], ge};
      rem_nxt  = ge ? (RW + 2)'(acc - trial) : (RW + 2)'(acc);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k]    <= x_in;
        root_r[k] <= root_nxt;
        rem_r[k]  <= rem_nxt;
        shd_r[k]  <= shd_in;
      end
    end
  end

  assign out_vld  = vld_r[RW-1];
  assign out_root = root_r[RW-1];
  assign out_shd  = shd_r[RW-1];

  // The final remainder never exceeds twice the root.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[RW-1] |-> (rem_r[RW-1] <= {1'b0, root_r[RW-1], 1'b0}))
    else $error("square root remainder out of bound");

endmodule

>>> src/vdl_atten.sv
// ----------------------------------------------------------------------------
// vdl_atten
// Attenuation denominator and a pipelined divide of 2^32 by it.
// ----------------------------------------------------------------------------
module vdl_atten (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  vdl_pkg::cfg_t              cfg,
  input  logic                       in_vld,
  input  logic [vdl_pkg::ROOT_W-1:0] in_dist,
  input  vdl_pkg::shd_t              in_shd,
  output logic                       out_vld,
  output logic [31:0]                out_atten,
  output vdl_pkg::shd_t              out_shd
);

  localparam int NW = vdl_pkg::DEN_W;
  localparam int QW = vdl_pkg::QUO_W;

  // Denominator stages.
  logic          a1_vld_r, a2_vld_r, a3_vld_r;
  logic [63:0]   ld1_r, dd1_r;
  logic [63:0]   ql2_r;
  logic [47:0]   qh2_r;
  logic [47:0]   lt2_r;
  logic [NW-1:0] den3_r;
  vdl_pkg::shd_t shd1_r, shd2_r, shd3_r;

  logic [47:0]   d2;
  logic [79:0]   qp;
  logic [47:0]   qt;
  logic [NW-1:0] den3_nxt;

  always_comb begin
    d2       = dd1_r[63:16];
    qp       = 80'(ql2_r) + {qh2_r, 32'b0};
    qt       = (|qp[79:64]) ? 48'hFFFF_FFFF_FFFF : qp[63:16];
    den3_nxt = NW'(cfg.att_const) + NW'(lt2_r) + NW'(qt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a1_vld_r <= 1'b0;
      a2_vld_r <= 1'b0;
      a3_vld_r <= 1'b0;
    end else if (en) begin
      a1_vld_r <= in_vld;
      a2_vld_r <= a1_vld_r;
      a3_vld_r <= a2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ld1_r  <= 64'(cfg.att_lin) * 64'(in_dist);
      dd1_r  <= 64'(in_dist) * 64'(in_dist);
      shd1_r <= in_shd;
      ql2_r  <= 64'(cfg.att_quad) * 64'(d2[31:0]);
      qh2_r  <= 48'(cfg.att_quad) * 48'(d2[47:32]);
      lt2_r  <= ld1_r[63:16];
      shd2_r <= shd1_r;
      den3_r <= den3_nxt;
      shd3_r <= shd2_r;
    end
  end

  // Restoring divide, one quotient bit per stage; the dividend is 2^32.
  logic          dv_vld_r [QW];
  logic [QW-1:0] q_r      [QW];
  logic [NW-1:0] rem_r    [QW];
  logic [NW-1:0] den_r    [QW];
  vdl_pkg::shd_t dshd_r   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic          vld_in;
    logic [QW-1:0] q_in;
    logic [NW-1:0] rem_in;
    logic [NW-1:0] den_in;
    vdl_pkg::shd_t shd_in;
    logic [NW:0]   part;
    logic          ge;

    if (k == 0) begin : g_head
      assign vld_in = a3_vld_r;
      assign q_in   = '0;
      assign rem_in = '0;
      assign den_in = den3_r;
      assign shd_in = shd3_r;
    end else begin : g_body
      assign vld_in = dv_vld_r[k-1];
      assign q_in   = q_r[k-1];
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign shd_in = dshd_r[k-1];
    end

    always_comb begin
      part = {rem_in, (k == 0) ? 1'b1 : 1'b0};
      ge   = (part >= {1'b0, den_in});
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[k] <= 1'b0;
      end else if (en) begin
        dv_vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k]    <= {q_in[QW-2:0], ge};
        rem_r[k]  <= ge ? NW'(part - {1'b0, den_in}) : NW'(part);
        den_r[k]  <= den_in;
        dshd_r[k] <= shd_in;
      end
    end
  end

  // A quotient of 2^32 or more, or a zero denominator, saturates.
  assign out_vld   = dv_vld_r[QW-1];
  assign out_atten = q_r[QW-1][QW-1] ? 32'hFFFF_FFFF : q_r[QW-1][31:0];
  assign out_shd   = dshd_r[QW-1];

  // A finished divide leaves a remainder below the denominator.
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_vld_r[QW-1] && (den_r[QW-1] != '0)) |-> (rem_r[QW-1] < den_r[QW-1]))
    else $error("divider remainder not below denominator");

endmodule

>>> src/vdl_shade.sv
// ----------------------------------------------------------------------------
// vdl_shade
// Diffuse factor and per channel color sum with clamping, four stages.
// ----------------------------------------------------------------------------
module vdl_shade (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  vdl_pkg::cfg_t cfg,
  input  logic          in_vld,
  input  logic [31:0]   in_atten,
  input  vdl_pkg::shd_t in_shd,
  output logic          out_vld,
  output vdl_pkg::out_t out_data
);

  localparam int FW = vdl_pkg::FACT_W;
  localparam logic [31:0] ATT_ONE = 32'h0001_0000;
  localparam logic [FW-1:0] FACT_MAX = '1;

  // Stage 1.
  logic          s1_vld_r;
  logic [63:0]   pl1_r;
  logic [39:0]   ph1_r;
  logic          neg1_r;
  logic [15:0]   ldmd1_r [4];
  logic [15:0]   lama1_r [4];
  logic [7:0]    me1_r   [4];
  // Stage 2.
  logic          s2_vld_r;
  logic [FW-1:0] fac2_r;
  logic          neg2_r;
  logic [15:0]   ldmd2_r [4];
  logic [15:0]   lama2_r [4];
  logic [7:0]    me2_r   [4];
  // Stage 3.
  logic          s3_vld_r;
  logic          neg3_r;
  logic [61:0]   dif3_r  [4];
  logic [32:0]   base3_r [4];
  // Stage 4, the output register.
  logic          s4_vld_r;
  vdl_pkg::out_t out_r;

  logic [31:0]   att;
  logic [15:0]   ldmd1_nxt [4];
  logic [15:0]   lama1_nxt [4];
  logic [7:0]    me1_nxt   [4];
  logic [71:0]   prod2;
  logic [FW-1:0] fac2_nxt;
  logic signed [63:0] tot4 [4];
  logic [7:0]    ch4 [4];

  // Attenuation select and the per channel color products.
  always_comb begin
    att = cfg.positional ? in_atten : ATT_ONE;
    for (int k = 0; k < 4; k++) begin
      ldmd1_nxt[k] = 16'(cfg.colors[31 - 8 * k -: 8]) * 16'(in_shd.mat_diffuse[31 - 8 * k -: 8]);
      lama1_nxt[k] = 16'(cfg.colors[63 - 8 * k -: 8]) * 16'(in_shd.mat_ambient[31 - 8 * k -: 8]);
      me1_nxt[k]   = in_shd.mat_emission[31 - 8 * k -: 8];
    end
  end

  // Factor from the split product, saturated.
  always_comb begin
    prod2    = 72'(pl1_r) + {ph1_r, 32'b0};
    fac2_nxt = (|prod2[71:62]) ? FACT_MAX : prod2[61:16];
  end

  // Signed channel sum and clamp to one byte.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      tot4[k] = neg3_r ? (64'(base3_r[k]) - 64'(dif3_r[k]))
                       : (64'(base3_r[k]) + 64'(dif3_r[k]));
      if (tot4[k][63] || (tot4[k] == 64'sd0)) begin
        ch4[k] = 8'd0;
      end else if (|tot4[k][63:32]) begin
        ch4[k] = 8'hFF;
      end else begin
        ch4[k] = tot4[k][31:24];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl1_r   <= 64'(att) * 64'(in_shd.magd[31:0]);
      ph1_r   <= 40'(att) * 40'(in_shd.magd[39:32]);
      neg1_r  <= in_shd.neg;
      ldmd1_r <= ldmd1_nxt;
      lama1_r <= lama1_nxt;
      me1_r   <= me1_nxt;
      fac2_r  <= fac2_nxt;
      neg2_r  <= neg1_r;
      ldmd2_r <= ldmd1_r;
      lama2_r <= lama1_r;
      me2_r   <= me1_r;
      neg3_r  <= neg2_r;
      for (int k = 0; k < 4; k++) begin
        dif3_r[k]  <= 62'(ldmd2_r[k]) * 62'(fac2_r);
        base3_r[k] <= 33'({me2_r[k], 24'b0}) + 33'({lama2_r[k], 16'b0});
      end
      out_r.red   <= ch4[0];
      out_r.green <= ch4[1];
      out_r.blue  <= ch4[2];
      out_r.alpha <= ch4[3];
    end
  end

  assign out_vld  = s4_vld_r;
  assign out_data = out_r;

endmodule

>>> src/vertex_diffuse_lighting_unit.sv
// ----------------------------------------------------------------------------
// vertex_diffuse_lighting_unit
// Per vertex diffuse lighting with one light and distance attenuation.
//
//   Port group | Direction | Handshake      | Beat
//   in_        | input     | valid / stall  | vdl_pkg::in_t vertex
//   out_       | output    | valid / stall  | vdl_pkg::out_t RGBA color
//   cfg_       | input     | valid / ready  | register index and 64 bit data
//
// One vertex enters per cycle while in_stall is low.
// Most of the pipe depth lies in the 32 stage square root and the 33 stage divider.
// Reset clears all valid bits and loads the light registers' reset values.
// All stages advance together; a stalled output register holds every stage.
// ----------------------------------------------------------------------------
module vertex_diffuse_lighting_unit #(
  parameter int COORD_WIDTH = vdl_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  vdl_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output vdl_pkg::out_t                 out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [vdl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data
);

  vdl_pkg::cfg_t cfg_r;
  logic          en;

  logic                       fr_vld;
  logic [63:0]                fr_sq;
  vdl_pkg::shd_t              fr_shd;
  logic                       sq_vld;
  logic [vdl_pkg::ROOT_W-1:0] sq_root;
  vdl_pkg::shd_t              sq_shd;
  logic                       at_vld;
  logic [31:0]                at_atten;
  vdl_pkg::shd_t              at_shd;

  // The whole pipe moves unless a finished beat is held at the output.
  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  // Light configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.light_x    <= '0;
      cfg_r.light_y    <= '0;
      cfg_r.light_z    <= '0;
      cfg_r.positional <= 1'b1;
      cfg_r.colors     <= '0;
      cfg_r.att_const  <= 32'h0001_0000;
      cfg_r.att_lin    <= '0;
      cfg_r.att_quad   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        vdl_pkg::CFG_LIGHT_X:    cfg_r.light_x    <= cfg_data[31:0];
        vdl_pkg::CFG_LIGHT_Y:    cfg_r.light_y    <= cfg_data[31:0];
        vdl_pkg::CFG_LIGHT_Z:    cfg_r.light_z    <= cfg_data[31:0];
        vdl_pkg::CFG_POSITIONAL: cfg_r.positional <= cfg_data[0];
        vdl_pkg::CFG_COLORS:     cfg_r.colors     <= cfg_data;
        vdl_pkg::CFG_ATT_CONST:  cfg_r.att_const  <= cfg_data[31:0];
        vdl_pkg::CFG_ATT_LIN:    cfg_r.att_lin    <= cfg_data[31:0];
        vdl_pkg::CFG_ATT_QUAD:   cfg_r.att_quad   <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  // Light vector, squared distance and dot product.
  vdl_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .cfg     (cfg_r),
    .in_vld  (in_valid),
    .in_data (in_data),
    .out_vld (fr_vld),
    .out_sq  (fr_sq),
    .out_shd (fr_shd)
  );

  // Distance.
  vdl_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (fr_vld),
    .in_x     (fr_sq),
    .in_shd   (fr_shd),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_shd  (sq_shd)
  );

  // Attenuation.
  vdl_atten u_atten (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .cfg       (cfg_r),
    .in_vld    (sq_vld),
    .in_dist   (sq_root),
    .in_shd    (sq_shd),
    .out_vld   (at_vld),
    .out_atten (at_atten),
    .out_shd   (at_shd)
  );

  // Color sum and output register.
  vdl_shade u_shade (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .cfg      (cfg_r),
    .in_vld   (at_vld),
    .in_atten (at_atten),
    .in_shd   (at_shd),
    .out_vld  (out_valid),
    .out_data (out_data)
  );

  // Input is held back only by a held output beat.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held output beat");

  // Reset empties the pipe.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

>>> test/vertex_diffuse_lighting_unit_tb.sv
// ----------------------------------------------------------------------------
// vertex_diffuse_lighting_unit_tb
// Streams vertices through the lighting unit under several light setups,
// with random gaps and output stalls, and compares every RGBA color with a
// fixed point prediction of the lighting equation.
// ----------------------------------------------------------------------------
module vertex_diffuse_lighting_unit_tb;

  localparam int LATENCY = 75;
  localparam longint CYCLE_LIMIT = 2000000;

  // Light setup held by the predictor.
  typedef struct {
    logic signed [31:0] lx, ly, lz;
    logic               pos;
    logic [63:0]        colors;
    logic [31:0]        catt, latt, qatt;
  } light_t;

  // Saturating helpers on 64 bit unsigned values.
  function automatic logic [63:0] mul_sat(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = a * b;
    return (p[127:64] != 0) ? '1 : p[63:0];
  endfunction

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = a + b;
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [63:0] root64(logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'h1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Computes the lit color of one vertex.
  function automatic vdl_pkg::out_t shade(light_t lt, vdl_pkg::in_t v);
    longint dx, dy, dz, dotp;
    logic [63:0] sq, dlen, d2, den, att, fac;
    logic [31:0] lamb, ldif;
    longint total, dif;
    logic neg;
    vdl_pkg::out_t r;
    lamb = lt.colors[63:32];
    ldif = lt.colors[31:0];
    if (lt.pos) begin
      dx = longint'(lt.lx) - longint'(v.point_x);
      dy = longint'(lt.ly) - longint'(v.point_y);
      dz = longint'(lt.lz) - longint'(v.point_z);
      if (dx > 64'sh7FFFFFFF) dx = 64'sh7FFFFFFF;
      if (dx < -64'sh80000000) dx = -64'sh80000000;
      if (dy > 64'sh7FFFFFFF) dy = 64'sh7FFFFFFF;
      if (dy < -64'sh80000000) dy = -64'sh80000000;
      if (dz > 64'sh7FFFFFFF) dz = 64'sh7FFFFFFF;
      if (dz < -64'sh80000000) dz = -64'sh80000000;
      sq = mul_sat(mag(dx), mag(dx));
      sq = add_sat(sq, mul_sat(mag(dy), mag(dy)));
      sq = add_sat(sq, mul_sat(mag(dz), mag(dz)));
      dlen = root64(sq);
      d2 = mul_sat(dlen, dlen) >> 16;
      den = 64'(lt.catt);
      den = add_sat(den, mul_sat(64'(lt.latt), dlen) >> 16);
      den = add_sat(den, mul_sat(64'(lt.qatt), d2) >> 16);
      if (den == 0) att = 64'hFFFFFFFF;
      else begin
        att = (64'h1 << 32) / den;
        if (att > 64'hFFFFFFFF) att = 64'hFFFFFFFF;
      end
    end else begin
      dx = longint'(lt.lx);
      dy = longint'(lt.ly);
      dz = longint'(lt.lz);
      att = 64'd65536;
    end
    dotp = longint'(v.normal_x) * dx + longint'(v.normal_y) * dy
         + longint'(v.normal_z) * dz;
    neg = dotp < 0;
    fac = mul_sat(att, mag(dotp) >> 14) >> 16;
    if (fac > 64'h3FFFFFFFFFFF) fac = 64'h3FFFFFFFFFFF;
    for (int k = 0; k < 4; k++) begin
      int sh;
      logic [7:0] ch;
      sh = 24 - 8 * k;
      dif = longint'((ldif >> sh) & 8'hFF) * longint'((v.mat_diffuse >> sh) & 8'hFF)
          * longint'(fac);
      total = longint'((lamb >> sh) & 8'hFF) * longint'((v.mat_ambient >> sh) & 8'hFF)
            * 65536 + longint'((v.mat_emission >> sh) & 8'hFF) * 16777216;
      total = neg ? total - dif : total + dif;
      if (total <= 0) ch = 8'd0;
      else if ((total >>> 24) > 255) ch = 8'd255;
      else ch = 8'(total >>> 24);
      case (k)
        0: r.red = ch;
        1: r.green = ch;
        2: r.blue = ch;
        default: r.alpha = ch;
      endcase
    end
    return r;
  endfunction

  // Holds the pending colors in arrival order and checks results against them.
  class color_scoreboard;
    vdl_pkg::out_t pending_colors[$];
    int errors;
    int checked;

    function void note_vertex(light_t lt, vdl_pkg::in_t v);
      pending_colors.push_back(shade(lt, v));
    endfunction

    function void check_color(vdl_pkg::out_t got);
      vdl_pkg::out_t want;
      if (pending_colors.size() == 0) begin
        $display("%0t: unexpected color %h", $time, got);
        errors++;
        return;
      end
      want = pending_colors.pop_front();
      checked++;
      if (got.red !== want.red)
        $display("%0t: red expected %h actual %h", $time, want.red, got.red);
      if (got.green !== want.green)
        $display("%0t: green expected %h actual %h", $time, want.green, got.green);
      if (got.blue !== want.blue)
        $display("%0t: blue expected %h actual %h", $time, want.blue, got.blue);
      if (got.alpha !== want.alpha)
        $display("%0t: alpha expected %h actual %h", $time, want.alpha, got.alpha);
      if (got !== want) errors++;
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  vdl_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  vdl_pkg::out_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [vdl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  color_scoreboard board = new();
  light_t light;
  longint cycles = 0;
  bit stall_enable = 1;
  int vertex_count = 0;

  vertex_diffuse_lighting_unit DUT (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // Short gaps mostly, a long one now and then.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Result side: sample at the rising edge, stall at random.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) board.check_color(out_data);
  end

  always @(negedge clk) begin
    int g;
    if (!stall_enable) out_stall <= 0;
    else begin
      g = $urandom_range(0, 99);
      out_stall <= (g < 25) ? 1'b1 : (g < 27 ? 1'b1 : 1'b0);
    end
  end

  // Writes one light register while the pipeline is empty.
  task automatic write_reg(logic [vdl_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
    case (idx)
      vdl_pkg::CFG_LIGHT_X:    light.lx = val[31:0];
      vdl_pkg::CFG_LIGHT_Y:    light.ly = val[31:0];
      vdl_pkg::CFG_LIGHT_Z:    light.lz = val[31:0];
      vdl_pkg::CFG_POSITIONAL: light.pos = val[0];
      vdl_pkg::CFG_COLORS:     light.colors = val;
      vdl_pkg::CFG_ATT_CONST:  light.catt = val[31:0];
      vdl_pkg::CFG_ATT_LIN:    light.latt = val[31:0];
      vdl_pkg::CFG_ATT_QUAD:   light.qatt = val[31:0];
      default: ;
    endcase
  endtask

  // Sends one vertex beat; consecutive beats keep valid high.
  task automatic send_vertex(vdl_pkg::in_t v, bit pace);
    int g;
    g = pace ? gap_len() : 0;
    if (g > 0) begin
      @(negedge clk);
      in_valid <= 0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1;
    in_data <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_vertex(light, v);
    vertex_count++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (board.pending_colors.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(0, 32'h000FFFFF) - 32'h00080000;
      2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return $urandom_range(0, 32'h03FFFFFF) - 32'h02000000;
    endcase
  endfunction

  function automatic vdl_pkg::in_t rnd_vertex();
    vdl_pkg::in_t v;
    int m;
    m = $urandom_range(0, 3);
    v.point_x = rnd_coord(m);
    v.point_y = rnd_coord(m);
    v.point_z = rnd_coord(m);
    if ($urandom_range(0, 3) == 0) begin
      v.normal_x = 16'($urandom);
      v.normal_y = 16'($urandom);
      v.normal_z = 16'($urandom);
    end else begin
      v.normal_x = 16'($urandom_range(0, 32768) - 16384);
      v.normal_y = 16'($urandom_range(0, 32768) - 16384);
      v.normal_z = 16'($urandom_range(0, 32768) - 16384);
    end
    v.mat_ambient = $urandom;
    v.mat_diffuse = $urandom;
    v.mat_emission = ($urandom_range(0, 2) == 0) ? $urandom : $urandom & 32'h1F1F1F1F;
    return v;
  endfunction

  // Loads a random light setup; extremes come up now and then.
  task automatic random_light();
    write_reg(vdl_pkg::CFG_LIGHT_X, {32'b0, rnd_coord($urandom_range(0, 3))});
    write_reg(vdl_pkg::CFG_LIGHT_Y, {32'b0, rnd_coord($urandom_range(0, 3))});
    write_reg(vdl_pkg::CFG_LIGHT_Z, {32'b0, rnd_coord($urandom_range(0, 3))});
    write_reg(vdl_pkg::CFG_POSITIONAL, {63'b0, 1'($urandom_range(0, 2) != 0)});
    write_reg(vdl_pkg::CFG_COLORS, {$urandom, $urandom});
    write_reg(vdl_pkg::CFG_ATT_CONST, {32'b0, $urandom_range(0, 4) == 0 ? 32'(0) :
              ($urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h3FFFF))});
    write_reg(vdl_pkg::CFG_ATT_LIN, {32'b0, $urandom_range(0, 2) == 0 ? 32'(0) :
              $urandom_range(0, 32'hFFFF)});
    write_reg(vdl_pkg::CFG_ATT_QUAD, {32'b0, $urandom_range(0, 2) == 0 ? 32'(0) :
              ($urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, 32'h3FF))});
  endtask

  initial begin
    vdl_pkg::in_t v;
    light = '{lx: 0, ly: 0, lz: 0, pos: 1, colors: 0, catt: 65536, latt: 0, qatt: 0};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Directed: zero attenuation denominator, extremes, both light kinds.
    write_reg(vdl_pkg::CFG_COLORS, 64'hFFFFFFFF_FFFFFFFF);
    write_reg(vdl_pkg::CFG_ATT_CONST, 0);
    write_reg(vdl_pkg::CFG_LIGHT_X, 32'h00010000);
    v = '0;
    send_vertex(v, 0);
    v.normal_x = 16'h4000; v.mat_diffuse = '1;
    send_vertex(v, 0);
    v.normal_x = 16'hC000; v.mat_ambient = '1; v.mat_emission = 32'h80808080;
    send_vertex(v, 0);
    v = '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 16'h7FFF, 16'h8000, 16'h7FFF,
          '1, '1, '1};
    send_vertex(v, 0);
    v = '{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 16'h8000, 16'h7FFF, 16'h8000,
          '1, '1, '0};
    send_vertex(v, 0);
    drain();
    write_reg(vdl_pkg::CFG_ATT_CONST, 32'hFFFFFFFF);
    write_reg(vdl_pkg::CFG_ATT_LIN, 32'hFFFFFFFF);
    write_reg(vdl_pkg::CFG_ATT_QUAD, 32'hFFFFFFFF);
    write_reg(vdl_pkg::CFG_LIGHT_Y, 32'h80000000);
    write_reg(vdl_pkg::CFG_LIGHT_Z, 32'h7FFFFFFF);
    repeat (6) send_vertex(rnd_vertex(), 0);
    drain();
    write_reg(vdl_pkg::CFG_POSITIONAL, 0);
    write_reg(vdl_pkg::CFG_COLORS, 64'h12345678_FFFFFFFF);
    v = '{0, 0, 0, 16'h4000, 16'h0000, 16'h0000, 32'h80808080, '1, 0};
    send_vertex(v, 0);
    v.normal_x = 16'hC000;
    send_vertex(v, 0);
    repeat (6) send_vertex(rnd_vertex(), 0);
    drain();

    // Random phases, each under its own light setup.
    for (int p = 0; p < 17; p++) begin
      random_light();
      stall_enable = (p % 4 != 3);
      for (int i = 0; i < 100; i++) send_vertex(rnd_vertex(), p % 4 != 2);
      drain();
    end

    $display("Checked %0d colors from %0d vertices over 17 random light setups,",
             board.checked, vertex_count);
    $display("with positional and directional lights, saturated inputs and stalls.");
    if (board.errors == 0 && board.pending_colors.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
